>>> hw/rtl/common_substring_span_remover_core_defines.svh
// Assertion macros for the span remover checker file.
`ifndef COMMON_SUBSTRING_SPAN_REMOVER_CORE_DEFINES_SVH
`define COMMON_SUBSTRING_SPAN_REMOVER_CORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define CSSR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CSSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cssr_pkg.sv
// Shared widths, codes and reset values of the common substring span remover.
package cssr_pkg;

  // Fixed field widths
  localparam int CHAR_W         = 16;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int SPAN_START_W   = 10;
  localparam int SPAN_LENGTH_W  = 9;

  // Request codes
  localparam logic REQ_REF   = 1'b0;
  localparam logic REQ_QUOTE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACES       = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] LENGTH_THRESHOLD_RST = 11'd10;
  localparam logic [CFG_W-1:0] MIN_SPACES_RST       = 11'd2;

  // Space character
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 16'h0020;

endpackage

>>> hw/rtl/common_substring_span_remover_core.sv
// Longest common substring finder between a stored reference and a streamed quote.
//
// Input channel (in_valid/in_ready): each transaction carries req_type, char_value
// and last. req_type REQ_REF appends a character to the reference (a reference
// character after a closed reference starts a new one); REQ_QUOTE feeds a quote.
// Output channel (out_valid/out_ready): one transaction per quote character with
// last set, giving remove, span_start and span_length of the longest match.
// Configuration: cfg_we writes cfg_wdata into the register chosen by cfg_index
// (0 length_threshold, 1 min_spaces); write only while the block is idle.
// Sequence: a reference character is handled as it is accepted. A quote character
// compared against a stored reference is accepted, then walks each reference entry
// through the reference and run-column memories, with a fill and a drain step. With
// no reference stored, or past QUOTE_MAX, the compare is skipped. A last quote
// character adds a space count, which reads the reference memory once per matched
// character, plus any wait for the output register to free.
// in_ready is high only while the sequencer is idle; a pending result in the
// output register does not block new transactions, but the next result waits
// until the held one is taken. Reset is synchronous: it empties the reference,
// drops any quote in progress and restores the register defaults.
module common_substring_span_remover_core #(
  parameter int REF_MAX   = 256,
  parameter int QUOTE_MAX = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 req_type,
  input  logic [cssr_pkg::CHAR_W-1:0]          char_value,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 remove,
  output logic [cssr_pkg::SPAN_START_W-1:0]    span_start,
  output logic [cssr_pkg::SPAN_LENGTH_W-1:0]   span_length,
  input  logic                                 cfg_we,
  input  logic [cssr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cssr_pkg::CFG_W-1:0]           cfg_wdata
);
  import cssr_pkg::*;

  localparam int RIW = $clog2(REF_MAX);
  localparam int RLW = $clog2(REF_MAX + 1);
  localparam int QPW = $clog2(QUOTE_MAX);
  localparam int QCW = $clog2(QUOTE_MAX + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_SETUP,
    S_CNT,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [CFG_W-1:0] length_threshold;
  logic [CFG_W-1:0] min_spaces;

  // Memories
  logic [CHAR_W-1:0] ref_mem [REF_MAX];
  logic [RLW-1:0]    run_mem [REF_MAX];
  logic [CHAR_W-1:0] ref_q;
  logic [RLW-1:0]    run_q;

  // Sequencer state
  logic              ref_closed;
  logic [RLW-1:0]    ref_len;
  logic [QCW-1:0]    qpos;
  logic [CHAR_W-1:0] quote_ch;
  logic              quote_last;
  logic [QPW-1:0]    quote_j;
  logic [RIW-1:0]    idx;
  logic [RIW-1:0]    p_idx;
  logic              p_vld;
  logic              issue_done;
  logic [RIW-1:0]    scan_idx;
  logic [RLW-1:0]    scan_left;
  logic [RLW-1:0]    spaces;

  // Best match so far
  logic [RLW-1:0] best_len;
  logic [RIW-1:0] best_end;
  logic [QPW-1:0] best_qstart;

  // Handshake and memory control
  logic           in_fire;
  logic           ref_load;
  logic           ref_room;
  logic [RIW-1:0] ref_waddr;
  logic [RIW-1:0] ref_raddr;
  logic [RIW-1:0] run_raddr;
  logic           run_we;
  logic           stage_empty;

  // Compare unit
  logic           hit;
  logic [RLW-1:0] cand_len;
  logic [RLW-1:0] len_now;
  logic           better;
  logic [31:0]    qstart_wide;
  logic [31:0]    scan_first_wide;
  logic           do_remove;
  logic [31:0]    start_ext;
  logic [31:0]    length_ext;

  assign in_ready    = (state == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign ref_load    = in_fire && (req_type == REQ_REF);
  assign ref_room    = ref_closed || (ref_len < RLW'(REF_MAX));
  assign ref_waddr   = ref_closed ? '0 : ref_len[RIW-1:0];
  assign ref_raddr   = (state == S_CMP) ? idx : scan_idx;
  assign run_raddr   = idx - RIW'(1);
  assign run_we      = (state == S_CMP) && p_vld;
  assign stage_empty = issue_done && !p_vld;

  // Extend the run of the diagonal neighbor on a character hit
  assign hit      = (ref_q == quote_ch);
  assign cand_len = ((p_idx == '0) || (quote_j == '0)) ? RLW'(1) : run_q + RLW'(1);
  assign len_now  = hit ? cand_len : '0;
  assign better   = hit && ((cand_len > best_len) ||
                            ((cand_len == best_len) && (p_idx < best_end)));
  assign qstart_wide     = 32'(quote_j) + 32'd1 - 32'(cand_len);
  assign scan_first_wide = 32'(best_end) + 32'd1 - 32'(best_len);

  // Removal decision and result sizing
  assign do_remove  = (best_len != '0) && (32'(best_len) > 32'(length_threshold)) &&
                      (32'(spaces) >= 32'(min_spaces));
  assign start_ext  = (best_len == '0) ? 32'd0 : 32'(best_qstart);
  assign length_ext = 32'(best_len);

  // Reference memory: write on load, registered read for compare and count
  always_ff @(posedge clk) begin
    if (ref_load && ref_room) begin
      ref_mem[ref_waddr] <= char_value;
    end
    ref_q <= ref_mem[ref_raddr];
  end

  // Run-column memory: read the diagonal neighbor, write the new run length
  always_ff @(posedge clk) begin
    if (run_we) begin
      run_mem[p_idx] <= len_now;
    end
    run_q <= run_mem[run_raddr];
  end

  // Sequencer, best-match tracking, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      length_threshold <= LENGTH_THRESHOLD_RST;
      min_spaces       <= MIN_SPACES_RST;
      ref_closed       <= 1'b1;
      ref_len          <= '0;
      qpos             <= '0;
      best_len         <= '0;
      best_end         <= '0;
      best_qstart      <= '0;
      p_vld            <= 1'b0;
      issue_done       <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      // Write configuration
      if (cfg_we) begin
        case (cfg_index)
          CFG_LENGTH_THRESHOLD: length_threshold <= cfg_wdata;
          CFG_MIN_SPACES:       min_spaces       <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop the held result once taken, unless a new one replaces it
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      // Mark a memory read in flight for the next cycle
      p_vld <= ((state == S_CMP) || (state == S_CNT)) && !issue_done;

      case (state)
        S_IDLE: begin
          if (ref_load) begin
            // Append to the reference and abort any quote
            qpos <= '0;
            if (ref_room) begin
              ref_len <= (ref_closed ? '0 : ref_len) + RLW'(1);
            end
            ref_closed <= last;
          end else if (in_fire) begin
            quote_ch   <= char_value;
            quote_last <= last;
            if (qpos == '0) begin
              best_len    <= '0;
              best_end    <= '0;
              best_qstart <= '0;
            end
            if (qpos < QCW'(QUOTE_MAX)) begin
              quote_j <= qpos[QPW-1:0];
              qpos    <= qpos + QCW'(1);
              if (ref_len != '0) begin
                idx        <= RIW'(ref_len - RLW'(1));
                issue_done <= 1'b0;
                state      <= S_CMP;
              end else if (last) begin
                state <= S_SETUP;
              end
            end else if (last) begin
              state <= S_SETUP;
            end
          end
        end

        S_CMP: begin
          // Issue reads from the top entry down, one per cycle
          if (!issue_done) begin
            p_idx      <= idx;
            idx        <= idx - RIW'(1);
            issue_done <= (idx == '0);
          end
          // Keep the best run, earliest reference end on ties
          if (p_vld && better) begin
            best_len    <= cand_len;
            best_end    <= p_idx;
            best_qstart <= qstart_wide[QPW-1:0];
          end
          if (stage_empty) begin
            state <= quote_last ? S_SETUP : S_IDLE;
          end
        end

        S_SETUP: begin
          // Point the space count at the matched reference span
          qpos       <= '0;
          scan_idx   <= scan_first_wide[RIW-1:0];
          scan_left  <= best_len;
          spaces     <= '0;
          issue_done <= (best_len == '0);
          state      <= S_CNT;
        end

        S_CNT: begin
          if (!issue_done) begin
            scan_idx   <= scan_idx + RIW'(1);
            scan_left  <= scan_left - RLW'(1);
            issue_done <= (scan_left == RLW'(1));
          end
          if (p_vld && (ref_q == SPACE_CHAR)) begin
            spaces <= spaces + RLW'(1);
          end
          if (stage_empty) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // Load the result once the output register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            remove      <= do_remove;
            span_start  <= start_ext[SPAN_START_W-1:0];
            span_length <= length_ext[SPAN_LENGTH_W-1:0];
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/cssr_checker.sv
// Port-level checker for the span remover core and its bind statement.
`include "common_substring_span_remover_core_defines.svh"

module cssr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                req_type,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                remove,
  input logic [cssr_pkg::SPAN_START_W-1:0]   span_start,
  input logic [cssr_pkg::SPAN_LENGTH_W-1:0]  span_length
);
  import cssr_pkg::*;

  // Hold a stalled result
  `CSSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(remove) && $stable(span_start) && $stable(span_length), "stalled result changed")

  // Flag removal only for a real match
  `CSSR_ASSERT_SAME(a_remove_len, out_valid && remove, span_length != '0, "removal with empty match")

  // Report start zero when nothing matched
  `CSSR_ASSERT_SAME(a_empty_start, out_valid && (span_length == '0), span_start == '0, "nonzero start with empty match")

  // A reference load never raises a result
  `CSSR_ASSERT_NEXT(a_ref_silent, in_valid && in_ready && (req_type == REQ_REF) && !out_valid, !out_valid, "result after reference load")

endmodule

bind common_substring_span_remover_core cssr_checker u_cssr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .req_type    (req_type),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .remove      (remove),
  .span_start  (span_start),
  .span_length (span_length)
);

>>> test/tb_common_substring_span_remover_core.sv
// Testbench for the common substring span remover core: predicts each span result and checks it.
`timescale 1ns / 1ps

module tb_common_substring_span_remover_core;
  import cssr_pkg::*;

  localparam int REF_DEPTH    = 256;
  localparam int QUOTE_DEPTH  = 1024;
  localparam int RIX_W        = $clog2(REF_DEPTH);
  localparam int RANDOM_ITEMS = 320;
  localparam int DRAIN_CYCLES = 2 * REF_DEPTH + 16;

  localparam logic [CHAR_W-1:0] CH_A = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_B = 16'h0062;
  localparam logic [CHAR_W-1:0] CH_C = 16'h0063;
  localparam logic [CHAR_W-1:0] CH_Z = 16'h007A;

  typedef logic [CHAR_W-1:0] text_q_t[$];

  typedef struct packed {
    logic                     remove;
    logic [SPAN_START_W-1:0]  span_start;
    logic [SPAN_LENGTH_W-1:0] span_length;
  } span_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     req_type = REQ_REF;
  logic [CHAR_W-1:0]        char_value = '0;
  logic                     last = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     remove;
  logic [SPAN_START_W-1:0]  span_start;
  logic [SPAN_LENGTH_W-1:0] span_length;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_LENGTH_THRESHOLD;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  // Span predictor state
  logic [CHAR_W-1:0]        ref_text [REF_DEPTH];
  logic [SPAN_LENGTH_W-1:0] run_len [REF_DEPTH];
  logic [SPAN_LENGTH_W-1:0] ref_count;
  logic [SPAN_START_W:0]    quote_pos;
  logic [SPAN_LENGTH_W-1:0] best_len;
  logic [RIX_W-1:0]         best_end;
  logic [SPAN_START_W-1:0]  best_qstart;
  logic                     ref_sealed;
  logic [CFG_W-1:0]         limit_len;
  logic [CFG_W-1:0]         limit_spaces;

  span_t   awaited_spans[$];
  text_q_t recent_ref;
  int      fail_count = 0;
  int      items_sent = 0;
  int      idle_max = 9;

  common_substring_span_remover_core #(
    .REF_MAX  (REF_DEPTH),
    .QUOTE_MAX(QUOTE_DEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .char_value (char_value),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .remove     (remove),
    .span_start (span_start),
    .span_length(span_length),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Abort a run that hangs
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    return (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
  endfunction

  function automatic void clear_quote_state();
    foreach (run_len[i]) run_len[i] = '0;
    best_len = '0;
    best_end = '0;
    best_qstart = '0;
  endfunction

  function automatic void reset_span_model();
    foreach (ref_text[i]) ref_text[i] = '0;
    ref_count = '0;
    quote_pos = '0;
    ref_sealed = 1'b1;
    limit_len = LENGTH_THRESHOLD_RST;
    limit_spaces = MIN_SPACES_RST;
    clear_quote_state();
  endfunction

  // Advance the predictor by one accepted transaction
  function automatic void predict_span(logic kind, logic [CHAR_W-1:0] ch, logic fin);
    int    len;
    int    j;
    int    lead;
    int    spaces;
    span_t res;
    if (kind == REQ_REF) begin
      quote_pos = '0;
      if (ref_sealed) begin
        ref_count = '0;
        ref_sealed = 1'b0;
      end
      if (ref_count < REF_DEPTH) begin
        ref_text[ref_count[RIX_W-1:0]] = ch;
        ref_count++;
      end
      if (fin) ref_sealed = 1'b1;
      return;
    end
    if (quote_pos == 0) clear_quote_state();
    if (quote_pos < QUOTE_DEPTH) begin
      j = int'(quote_pos);
      // Walk the column from the top so run_len[i-1] still holds the previous column
      for (int i = int'(ref_count) - 1; i >= 0; i--) begin
        if (ref_text[RIX_W'(i)] == ch) begin
          len = (i == 0 || j == 0) ? 1 : int'(run_len[RIX_W'(i - 1)]) + 1;
          if (len > best_len || (len == best_len && i < best_end)) begin
            best_len = SPAN_LENGTH_W'(len);
            best_end = RIX_W'(i);
            best_qstart = SPAN_START_W'(j + 1 - len);
          end
        end else begin
          len = 0;
        end
        run_len[RIX_W'(i)] = SPAN_LENGTH_W'(len);
      end
      quote_pos++;
    end
    if (!fin) return;
    res = '0;
    spaces = 0;
    if (best_len != 0) begin
      lead = int'(best_end) + 1 - int'(best_len);
      for (int k = 0; k < int'(best_len); k++)
        if (ref_text[RIX_W'(lead + k)] == SPACE_CHAR) spaces++;
      res.remove = (best_len > limit_len) && (spaces >= limit_spaces);
      res.span_start = best_qstart;
    end
    res.span_length = best_len;
    awaited_spans = {awaited_spans, res};
    quote_pos = '0;
  endfunction

  // Compare each delivered span with the oldest prediction
  always @(posedge clk) begin : check_spans
    span_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_spans.size() == 0) begin
        $error("span result with no prediction pending");
        fail_count++;
      end else begin
        want = awaited_spans.pop_front();
        if (remove !== want.remove) begin
          $error("remove: expected %0d, got %0d", want.remove, remove);
          fail_count++;
        end
        if (span_start !== want.span_start) begin
          $error("span_start: expected %0d, got %0d", want.span_start, span_start);
          fail_count++;
        end
        if (span_length !== want.span_length) begin
          $error("span_length: expected %0d, got %0d", want.span_length, span_length);
          fail_count++;
        end
      end
    end
  end

  // Stall the result channel a random number of cycles per transaction
  initial begin : drive_out_ready
    int gap;
    @(negedge rst);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_item(logic kind, logic [CHAR_W-1:0] ch, logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    char_value <= ch;
    last       <= fin;
    do @(posedge clk); while (!in_ready);
    predict_span(kind, ch, fin);
    items_sent++;
  endtask

  // Send a whole text, last set on its final character
  task automatic send_text(logic kind, text_q_t text);
    if (kind == REQ_REF) recent_ref = text;
    foreach (text[i]) send_item(kind, text[i], i == text.size() - 1);
  endtask

  // Hold the input until every predicted span has been delivered
  task automatic pause_for_spans();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_spans.size() != 0);
  endtask

  // Drain and let a trailing compare pass finish before a register write
  task automatic settle();
    pause_for_spans();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_limits(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] spc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LENGTH_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    limit_len = thr;
    cfg_index <= CFG_MIN_SPACES;
    cfg_wdata <= spc;
    @(posedge clk);
    limit_spaces = spc;
    cfg_we <= 1'b0;
  endtask

  // Mostly spaces and a small alphabet so long matches occur; some full-range values
  function automatic logic [CHAR_W-1:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return SPACE_CHAR;
    if (r < 85) return CH_A + CHAR_W'($urandom_range(0, 2));
    return CHAR_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic text_q_t make_reference();
    text_q_t text;
    int      n;
    if ($urandom_range(0, 39) == 0) n = $urandom_range(REF_DEPTH, REF_DEPTH + 2);
    else if ($urandom_range(0, 9) == 0) n = $urandom_range(25, 80);
    else n = $urandom_range(1, 24);
    repeat (n) text = {text, random_char()};
    return text;
  endfunction

  // Splice pieces of the recent reference with random characters
  function automatic text_q_t make_quote();
    text_q_t text;
    int      n;
    int      st;
    int      cnt;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
    while (text.size() < n) begin
      if (recent_ref.size() > 0 && $urandom_range(0, 2) != 0) begin
        st = $urandom_range(0, recent_ref.size() - 1);
        cnt = $urandom_range(1, recent_ref.size() - st);
        for (int k = 0; k < cnt; k++) text = {text, recent_ref[st + k]};
      end else begin
        text = {text, random_char()};
      end
    end
    while (text.size() > n) void'(text.pop_back());
    return text;
  endfunction

  task automatic test_empty_reference();
    send_item(REQ_QUOTE, CH_A, 1'b0);
    send_item(REQ_QUOTE, 16'hFFFF, 1'b1);
    send_item(REQ_QUOTE, 16'h0000, 1'b1);
  endtask

  // Ties, no match and the extreme character values
  task automatic test_match_rules();
    text_q_t text;
    settle();
    program_limits(11'd3, 11'd1);
    text = '{CH_A, SPACE_CHAR, CH_B, SPACE_CHAR, CH_A, SPACE_CHAR, CH_B, 16'hFFFF, 16'h0000};
    send_text(REQ_REF, text);
    text = '{SPACE_CHAR, CH_B, SPACE_CHAR, CH_A, CH_Z};
    send_text(REQ_QUOTE, text);
    text = '{16'hFFFF, 16'h0000, SPACE_CHAR};
    send_text(REQ_QUOTE, text);
    text = '{16'h1234};
    send_text(REQ_QUOTE, text);
  endtask

  // Quote against a reference whose last character is still to come
  task automatic test_unfinished_reference();
    send_item(REQ_REF, CH_A, 1'b0);
    send_item(REQ_REF, CH_B, 1'b0);
    send_item(REQ_REF, SPACE_CHAR, 1'b0);
    send_text(REQ_QUOTE, '{CH_B, SPACE_CHAR});
    send_text(REQ_REF, '{CH_A, CH_B});
    send_text(REQ_QUOTE, '{SPACE_CHAR, CH_A, CH_B});
  endtask

  // A reference load drops the quote in progress
  task automatic test_quote_abort();
    send_text(REQ_REF, '{CH_C, CH_A});
    send_item(REQ_QUOTE, CH_C, 1'b0);
    send_item(REQ_QUOTE, CH_A, 1'b0);
    send_text(REQ_REF, '{CH_A, SPACE_CHAR});
    send_text(REQ_QUOTE, '{CH_A, SPACE_CHAR});
  endtask

  // Overlong reference: extra characters dropped, the dropped last still closes it
  task automatic test_reference_overflow();
    text_q_t text;
    text_q_t quote;
    settle();
    program_limits(11'd255, 11'd1);
    repeat (REF_DEPTH + 4) text = {text, random_char()};
    send_text(REQ_REF, text);
    for (int k = 0; k < REF_DEPTH; k++) quote = {quote, text[k]};
    send_text(REQ_QUOTE, quote);
    send_text(REQ_QUOTE, '{text[REF_DEPTH + 1]});
  endtask

  // Overlong quote: a match at the final compared position, the rest dropped
  task automatic test_quote_overflow();
    text_q_t quote;
    send_text(REQ_REF, '{CH_B, CH_C});
    repeat (QUOTE_DEPTH - 1) quote = {quote, CH_Z};
    quote = {quote, CH_B};
    quote = {quote, CH_C};
    quote = {quote, CH_Z};
    quote = {quote, CH_B};
    send_text(REQ_QUOTE, quote);
  endtask

  task automatic run_random_sequence();
    int      sel;
    text_q_t text;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
      // fresh reference, then quotes built from it
      send_text(REQ_REF, make_reference());
      repeat ($urandom_range(1, 4)) send_text(REQ_QUOTE, make_quote());
    end else if (sel < 78) begin
      // unstructured transactions
      repeat ($urandom_range(1, 8))
        send_item($urandom_range(0, 1) ? REQ_QUOTE : REQ_REF, random_char(),
                  $urandom_range(0, 3) == 0);
    end else if (sel < 90) begin
      // break off a quote with a reference load
      text = make_quote();
      foreach (text[i]) send_item(REQ_QUOTE, text[i], 1'b0);
      send_text(REQ_REF, make_reference());
      send_text(REQ_QUOTE, make_quote());
    end else begin
      // quote while the reference is still open, then extend it
      text = make_reference();
      foreach (text[i]) send_item(REQ_REF, text[i], 1'b0);
      recent_ref = text;
      send_text(REQ_QUOTE, make_quote());
      send_text(REQ_REF, make_reference());
      send_text(REQ_QUOTE, make_quote());
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    int base;
    phase = 0;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      // close any open quote so the block is idle for the register write
      if (quote_pos != 0) send_item(REQ_QUOTE, random_char(), 1'b1);
      settle();
      case (phase)
        0: program_limits(11'd0, 11'd0);
        1: program_limits(11'd1024, 11'd1024);
        2: program_limits(11'd1024, 11'd0);
        3: program_limits(11'd0, 11'd1024);
        default: begin
          if ($urandom_range(0, 4) == 0)
            program_limits(CFG_W'($urandom_range(0, 1024)), CFG_W'($urandom_range(0, 1024)));
          else
            program_limits(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 4)));
        end
      endcase
      idle_max = (phase % 3 == 2) ? 0 : 9;
      repeat (2) begin
        run_random_sequence();
        if ($urandom_range(0, 19) == 0) pause_for_spans();
      end
      phase++;
    end
    idle_max = 9;
  endtask

  initial begin
    reset_span_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_reference();
    test_match_rules();
    test_unfinished_reference();
    test_quote_abort();
    test_reference_overflow();
    test_quote_overflow();
    test_random_traffic();
    settle();
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
